// ----- hw/rtl/rfc_pkg.sv -----
// rfc_pkg: shared constants for the response frame checker
// register indexes, result codes, widths and reset values
// no dependencies
`timescale 1ns / 1ps

package rfc_pkg;

  // field widths
  localparam int unsigned CountW  = 13;
  localparam int unsigned HdrW    = 5;
  localparam int unsigned CodeW   = 16;
  localparam int unsigned OpW     = 2;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ResultW = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  // largest frame that is counted, bytes beyond it are dropped
  localparam logic [CountW-1:0] MaxFrame = CountW'(4096);

  // input operations
  localparam logic [OpW-1:0] OpData      = 2'd0;
  localparam logic [OpW-1:0] OpEnd       = 2'd1;
  localparam logic [OpW-1:0] OpTransport = 2'd2;

  // result codes
  localparam logic [ResultW-1:0] RcOk        = 3'd0;
  localparam logic [ResultW-1:0] RcFailed    = 3'd1;
  localparam logic [ResultW-1:0] RcBusy      = 3'd2;
  localparam logic [ResultW-1:0] RcProto     = 3'd3;
  localparam logic [ResultW-1:0] RcTransport = 3'd4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegHeaderLength   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegExpectedLength = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOkCode         = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFailedCode     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBusyCode       = 3'd4;

  // configuration reset values
  localparam logic [HdrW-1:0]   HeaderLengthRst   = 5'd8;
  localparam logic [CountW-1:0] ExpectedLengthRst = 13'd0;
  localparam logic [CodeW-1:0]  OkCodeRst         = 16'd1542;
  localparam logic [CodeW-1:0]  FailedCodeRst     = 16'd5397;
  localparam logic [CodeW-1:0]  BusyCodeRst       = 16'd5140;

endpackage

// ----- hw/rtl/response_frame_checker.sv -----
// response_frame_checker: byte-wise response frame checker, top level
// depends on rfc_pkg
`timescale 1ns / 1ps

// an item is taken into the input register, and its result is then held in the output register
// throughput: one item per cycle while no result is stalled, set by the single input register and frame state update
// the input side stalls only while a result waits in the output register and is stalled
// reset (asynchronous, active low) clears frame state, pipeline valids and loads
// configuration defaults; no clearing pass is needed

module response_frame_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rfc_pkg::OpW-1:0]       op_i,
  input  logic [rfc_pkg::ByteW-1:0]     data_byte_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rfc_pkg::ResultW-1:0]   result_code_o,
  output logic [rfc_pkg::CountW-1:0]    frame_length_o,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rfc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rfc_pkg::CfgDatW-1:0]   cfg_data_i
);

  import rfc_pkg::*;

  // configuration registers
  logic [HdrW-1:0]   header_length_q;
  logic [CountW-1:0] expected_length_q;
  logic [CodeW-1:0]  ok_code_q;
  logic [CodeW-1:0]  failed_code_q;
  logic [CodeW-1:0]  busy_code_q;

  // input stage
  logic              in_valid_q, in_valid_d;
  logic [OpW-1:0]    op_q;
  logic [ByteW-1:0]  byte_q;

  // frame state
  logic [CountW-1:0] count_q, count_d;
  logic [CodeW-1:0]  status_q, status_d;
  logic [ByteW-1:0]  sum_q, sum_d;
  logic              ovf_q, ovf_d;

  // output stage
  logic               out_valid_q, out_valid_d;
  logic [ResultW-1:0] rc_q, rc_d;
  logic [CountW-1:0]  len_q;

  logic in_xfer;
  logic out_free;
  logic has_result;
  logic proceed;
  logic [ResultW-1:0] status_rc;
  logic [ResultW-1:0] judge_rc;
  logic [CountW-1:0]  hdr_len_ext;

  assign cfg_ready_o = 1'b1;

  // configuration register writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_length_q   <= HeaderLengthRst;
      expected_length_q <= ExpectedLengthRst;
      ok_code_q         <= OkCodeRst;
      failed_code_q     <= FailedCodeRst;
      busy_code_q       <= BusyCodeRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegHeaderLength:   header_length_q   <= cfg_data_i[HdrW-1:0];
        RegExpectedLength: expected_length_q <= cfg_data_i[CountW-1:0];
        RegOkCode:         ok_code_q         <= cfg_data_i[CodeW-1:0];
        RegFailedCode:     failed_code_q     <= cfg_data_i[CodeW-1:0];
        RegBusyCode:       busy_code_q       <= cfg_data_i[CodeW-1:0];
        default: ;
      endcase
    end
  end

  // handshake between the stages
  assign has_result = (op_q == OpEnd) || (op_q == OpTransport);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign proceed    = in_valid_q && (!has_result || out_free);
  assign in_stall_o = in_valid_q && !proceed;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign in_valid_d = in_xfer || (in_valid_q && !proceed);

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q   <= op_i;
      byte_q <= data_byte_i;
    end
  end

  // status word mapping, first match wins
  always_comb begin
    if (status_q == ok_code_q) begin
      status_rc = RcOk;
    end else if (status_q == failed_code_q) begin
      status_rc = RcFailed;
    end else if (status_q == busy_code_q) begin
      status_rc = RcBusy;
    end else begin
      status_rc = RcProto;
    end
  end

  // end of frame judgement
  assign hdr_len_ext = {{(CountW-HdrW){1'b0}}, header_length_q};

  always_comb begin
    judge_rc = status_rc;
    if (expected_length_q != '0) begin
      if (count_q == expected_length_q) begin
        if (sum_q != '0) begin
          judge_rc = RcProto;
        end
      end else if (count_q != hdr_len_ext) begin
        judge_rc = RcProto;
      end
    end
    if (ovf_q || (count_q < hdr_len_ext)) begin
      judge_rc = RcProto;
    end
  end

  // frame state update and result selection
  always_comb begin
    count_d  = count_q;
    status_d = status_q;
    sum_d    = sum_q;
    ovf_d    = ovf_q;
    rc_d     = judge_rc;
    if (proceed) begin
      case (op_q)
        OpData: begin
          if (count_q >= MaxFrame) begin
            ovf_d = 1'b1;
          end else begin
            if (count_q == CountW'(0)) begin
              status_d = {byte_q, status_q[ByteW-1:0]};
            end else if (count_q == CountW'(1)) begin
              status_d = {status_q[CodeW-1:ByteW], byte_q};
            end
            if (count_q >= hdr_len_ext) begin
              sum_d = sum_q + byte_q;
            end
            count_d = count_q + CountW'(1);
          end
        end
        OpEnd: begin
          rc_d     = judge_rc;
          count_d  = '0;
          status_d = '0;
          sum_d    = '0;
          ovf_d    = 1'b0;
        end
        OpTransport: begin
          rc_d     = RcTransport;
          count_d  = '0;
          status_d = '0;
          sum_d    = '0;
          ovf_d    = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      status_q <= '0;
      sum_q    <= '0;
      ovf_q    <= 1'b0;
    end else begin
      count_q  <= count_d;
      status_q <= status_d;
      sum_q    <= sum_d;
      ovf_q    <= ovf_d;
    end
  end

  // output register
  assign out_valid_d = (proceed && has_result) || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proceed && has_result) begin
      rc_q  <= rc_d;
      len_q <= count_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_code_o  = rc_q;
  assign frame_length_o = len_q;

endmodule

// ----- hw/rtl/rfc_checker.sv -----
// rfc_checker: port-level assertions for response_frame_checker, with its bind
// depends on rfc_pkg and response_frame_checker
`timescale 1ns / 1ps

module rfc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [rfc_pkg::ResultW-1:0]   result_code_o,
  input logic [rfc_pkg::CountW-1:0]    frame_length_o
);

  import rfc_pkg::*;

  // a result waiting under stall holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_code_o)
      && $stable(frame_length_o))
    else $error("stalled result changed");

  // result codes stay within the defined set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (result_code_o == RcOk) || (result_code_o == RcFailed)
      || (result_code_o == RcBusy) || (result_code_o == RcProto)
      || (result_code_o == RcTransport))
    else $error("undefined result code");

  // reported length never exceeds the saturation point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> frame_length_o <= MaxFrame)
    else $error("frame length beyond saturation");

  // input side stalls only behind a blocked result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

endmodule

bind response_frame_checker rfc_checker u_rfc_checker (.*);
